// ===== sv/ltip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltip_pkg: shared types and constants
// Request and response layouts, lane control, codes and sequencer states for
// the look-ahead target interpolator.
// ----------------------------------------------------------------------------
package ltip_pkg;

  localparam int JOINT_COUNT = 7;
  localparam int POS_W       = 32;
  localparam int STAMP_W     = 48;
  localparam int TIME_W      = 24;
  localparam int ALPHA_W     = 17;
  localparam int RATIO_W     = 17;
  localparam int DIV_STEPS   = 17;
  localparam int PLAY_W      = 50;

  localparam logic [TIME_W-1:0]  GAP_MIN     = 24'd1000;
  localparam logic [TIME_W:0]    SPAN_MARGIN = 25'd50000;
  localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 17'd7;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = 17'd65536;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_STALE    = 2'd1,
    STAT_BACKWARD = 2'd2,
    STAT_NO_STAMP = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_LOOKAHEAD_ENABLE = 3'd0,
    REG_LOOKAHEAD_DELAY  = 3'd1,
    REG_BUFFER_DURATION  = 3'd2,
    REG_FILTER_ALPHA     = 3'd3,
    REG_MAX_GAP          = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_P_RD,
    S_P_CHK,
    S_P_TRIM_RD,
    S_P_TRIM_CHK,
    S_T_BEGIN,
    S_T_OLD,
    S_T_NEW,
    S_T_SCAN_RD,
    S_T_SCAN_CHK,
    S_T_DIV,
    S_T_RDA,
    S_T_RDB,
    S_T_DIRECT,
    S_T_HOLD,
    S_T_MUL1,
    S_T_RAW,
    S_T_MUL2,
    S_T_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [STAMP_W-1:0]       sample_stamp;
    logic [STAMP_W-1:0]       now_time;
    logic signed [POS_W-1:0]  pos_0;
    logic signed [POS_W-1:0]  pos_1;
    logic signed [POS_W-1:0]  pos_2;
    logic signed [POS_W-1:0]  pos_3;
    logic signed [POS_W-1:0]  pos_4;
    logic signed [POS_W-1:0]  pos_5;
    logic signed [POS_W-1:0]  pos_6;
  } ltip_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     target_valid;
    logic signed [POS_W-1:0]  out_0;
    logic signed [POS_W-1:0]  out_1;
    logic signed [POS_W-1:0]  out_2;
    logic signed [POS_W-1:0]  out_3;
    logic signed [POS_W-1:0]  out_4;
    logic signed [POS_W-1:0]  out_5;
    logic signed [POS_W-1:0]  out_6;
  } ltip_out_t;

  typedef logic [JOINT_COUNT-1:0][POS_W-1:0] pos_row_t;

  typedef struct packed {
    logic mul1_en;
    logic raw_en;
    logic mul2_en;
    logic upd_en;
    logic load_raw;
    logic load_start;
  } lane_ctl_t;

endpackage

// ===== sv/ltip_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltip_lane: one joint of interpolation and filtering
// Blends two samples by a Q1.16 ratio, then runs the exponential filter that
// holds this joint's target.
// ----------------------------------------------------------------------------
module ltip_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ltip_pkg::lane_ctl_t              ctl,
  input  logic signed [ltip_pkg::POS_W-1:0] pos_a,
  input  logic signed [ltip_pkg::POS_W-1:0] pos_b,
  input  logic [ltip_pkg::RATIO_W-1:0]     ratio,
  input  logic [ltip_pkg::ALPHA_W-1:0]     alpha,
  input  logic signed [ltip_pkg::POS_W-1:0] start_pos,
  output logic signed [ltip_pkg::POS_W-1:0] filt
);

  logic signed [32:0] diff1;
  logic signed [50:0] prod1_r;
  logic signed [31:0] a_r;
  logic signed [31:0] raw_r;
  logic signed [32:0] diff2;
  logic signed [50:0] prod2_r;
  logic signed [51:0] rnd;
  logic signed [31:0] filt_r;

  assign diff1 = 33'(pos_b) - 33'(pos_a);
  assign diff2 = 33'(raw_r) - 33'(filt_r);
  assign rnd   = 52'(prod2_r) + 52'sd32768;
  assign filt  = filt_r;

  always_ff @(posedge clk) begin
    if (ctl.mul1_en) begin
      prod1_r <= 51'(diff1 * $signed({1'b0, ratio}));
      a_r     <= pos_a;
    end
    if (ctl.raw_en) begin
      raw_r <= a_r + prod1_r[47:16];
    end
    if (ctl.mul2_en) begin
      prod2_r <= 51'(diff2 * $signed({1'b0, alpha}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (ctl.load_start) begin
      filt_r <= start_pos;
    end else if (ctl.load_raw) begin
      filt_r <= raw_r;
    end else if (ctl.upd_en) begin
      filt_r <= filt_r + rnd[47:16];
    end
  end

endmodule

// ===== sv/ltip_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltip_divider: serial ratio divider
// Restoring division giving floor(num * 65536 / den), one quotient bit per
// cycle, for num no larger than den.
// ----------------------------------------------------------------------------
module ltip_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [ltip_pkg::TIME_W-1:0]    num,
  input  logic [ltip_pkg::TIME_W-1:0]    den,
  output logic                           done,
  output logic [ltip_pkg::RATIO_W-1:0]   quot
);

  logic [24:0] rem_r, rem_nxt, trial;
  logic [23:0] den_r;
  logic [16:0] q_r;
  logic [4:0]  cnt_r;
  logic        run_r, done_r, ge;

  // first step takes the integer bit, the rest shift in fraction bits
  always_comb begin
    trial   = (cnt_r == 5'(ltip_pkg::DIV_STEPS)) ? rem_r : {rem_r[23:0], 1'b0};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? trial - {1'b0, den_r} : trial;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= {1'b0, num};
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[15:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'(ltip_pkg::DIV_STEPS);
    end else if (run_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== sv/lookahead_target_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookahead_target_interpolator: delayed playback of buffered joint targets
// Ring buffer of timestamped samples, bracketing search, linear blend and
// exponential filter, with one lane per joint.
// ----------------------------------------------------------------------------
// Sequence: start loads the filter, an unused opcode only strobes; a push reads
//   the newest entry, then rejects the sample or stores it and trims old entries
//   one read and compare at a time; a tick runs the stamp scan (one memory read
//   and compare per entry), the 17-step divider when it blends, then the lanes.
// Throughput: one request at a time; busy stays high through the strobe cycle.
// Result: out_strobe is high for one cycle; the receiver cannot stall.
// Reset: synchronous, active low; empties the buffer, clears the filter and
//   loads register defaults. No clearing pass: unwritten entries are never read.
module lookahead_target_interpolator #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ltip_pkg::ltip_in_t   in_req,
  output logic                 out_strobe,
  output ltip_pkg::ltip_out_t  out_rsp,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data
);

  localparam int PW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int JC = ltip_pkg::JOINT_COUNT;

  // configuration registers
  logic        en_r;
  logic [23:0] delay_r, dur_r, gap_r;
  logic [16:0] alpha_r;

  // control state
  ltip_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          fvalid_r, fvalid_nxt;

  // payload
  ltip_pkg::ltip_in_t req_r;
  logic [47:0]        stamp_r, prev_r, prev_nxt;
  logic signed [49:0] play_r;
  logic [1:0]         status_r, status_nxt;
  logic [PW-1:0]      pv_r, pv_nxt, nx_r, nx_nxt, dir_r, dir_nxt;
  logic [16:0]        ratio_r, ratio_nxt;
  ltip_pkg::pos_row_t hold_r, req_row;

  // memories
  logic [47:0]        stamp_mem [BUFFER_DEPTH];
  ltip_pkg::pos_row_t pos_mem   [BUFFER_DEPTH];
  logic [47:0]        stamp_q_r;
  ltip_pkg::pos_row_t pos_q_r;
  logic [PW-1:0]      rd_addr, wr_addr;
  logic               wr_en, hold_en;

  // derived limits
  logic [23:0] gap_eff;
  logic [24:0] span_eff, dl_gap, keep;
  logic [26:0] stale_lim;
  logic [16:0] alpha_eff;
  logic        accept, stale, full;
  logic [47:0] stamp_in, gap_cur;
  logic signed [49:0] stamp_q_s, play_diff;

  ltip_pkg::lane_ctl_t lane_ctl;
  logic                div_go, div_done;
  logic [16:0]         div_quot;
  logic [31:0]         filt [JC];

  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW + 1 - PW){1'b0}}, base} + {1'b0, k};
    if (s >= (CW + 1)'(BUFFER_DEPTH)) begin
      s = s - (CW + 1)'(BUFFER_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign accept   = start && !busy;
  assign busy     = state_r != ltip_pkg::S_IDLE;
  assign full     = count_r == CW'(BUFFER_DEPTH);
  assign stamp_in = (in_req.sample_stamp != '0) ? in_req.sample_stamp : in_req.now_time;

  // clamp the registers to their working ranges
  always_comb begin
    gap_eff   = (gap_r < ltip_pkg::GAP_MIN) ? ltip_pkg::GAP_MIN : gap_r;
    span_eff  = ({1'b0, delay_r} + ltip_pkg::SPAN_MARGIN > {1'b0, dur_r}) ?
                {1'b0, delay_r} + ltip_pkg::SPAN_MARGIN : {1'b0, dur_r};
    dl_gap    = {1'b0, delay_r} + {1'b0, gap_eff};
    keep      = (dl_gap > span_eff) ? dl_gap : span_eff;
    stale_lim = {2'b00, span_eff} + {3'b000, delay_r} + {3'b000, gap_eff};
    if (alpha_r < ltip_pkg::ALPHA_MIN) begin
      alpha_eff = ltip_pkg::ALPHA_MIN;
    end else if (alpha_r > ltip_pkg::ALPHA_MAX) begin
      alpha_eff = ltip_pkg::ALPHA_MAX;
    end else begin
      alpha_eff = alpha_r;
    end
  end

  assign stale     = (req_r.now_time > stamp_r) &&
                     (req_r.now_time - stamp_r > {21'd0, stale_lim});
  assign stamp_q_s = $signed({2'b00, stamp_q_r});
  assign play_diff = play_r - $signed({2'b00, prev_r});
  assign gap_cur   = stamp_q_r - prev_r;

  assign req_row[0] = req_r.pos_0;
  assign req_row[1] = req_r.pos_1;
  assign req_row[2] = req_r.pos_2;
  assign req_row[3] = req_r.pos_3;
  assign req_row[4] = req_r.pos_4;
  assign req_row[5] = req_r.pos_5;
  assign req_row[6] = req_r.pos_6;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b1;
      delay_r <= 24'd80000;
      dur_r   <= 24'd500000;
      alpha_r <= 17'd1311;
      gap_r   <= 24'd250000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ltip_pkg::REG_LOOKAHEAD_ENABLE: en_r    <= cfg_data[0];
        ltip_pkg::REG_LOOKAHEAD_DELAY:  delay_r <= cfg_data;
        ltip_pkg::REG_BUFFER_DURATION:  dur_r   <= cfg_data;
        ltip_pkg::REG_FILTER_ALPHA:     alpha_r <= cfg_data[16:0];
        ltip_pkg::REG_MAX_GAP:          gap_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ltip_pkg::S_IDLE: begin
        if (accept) begin
          case (in_req.opcode)
            ltip_pkg::OP_PUSH:  state_nxt = ltip_pkg::S_P_RD;
            ltip_pkg::OP_TICK:  state_nxt = ltip_pkg::S_T_BEGIN;
            ltip_pkg::OP_START: state_nxt = ltip_pkg::S_START;
            default:            state_nxt = ltip_pkg::S_DONE;
          endcase
        end
      end
      ltip_pkg::S_START: state_nxt = ltip_pkg::S_DONE;
      ltip_pkg::S_P_RD:  state_nxt = ltip_pkg::S_P_CHK;
      ltip_pkg::S_P_CHK: begin
        if (stamp_r == '0 || stale ||
            (count_r != '0 && stamp_r <= stamp_q_r)) begin
          state_nxt = ltip_pkg::S_DONE;
        end else begin
          state_nxt = ltip_pkg::S_P_TRIM_RD;
        end
      end
      ltip_pkg::S_P_TRIM_RD: begin
        state_nxt = (count_r > CW'(2)) ? ltip_pkg::S_P_TRIM_CHK : ltip_pkg::S_DONE;
      end
      ltip_pkg::S_P_TRIM_CHK: begin
        state_nxt = ({1'b0, stamp_q_r} + {24'd0, keep} < {1'b0, stamp_r}) ?
                    ltip_pkg::S_P_TRIM_RD : ltip_pkg::S_DONE;
      end
      ltip_pkg::S_T_BEGIN: begin
        if (count_r == '0) begin
          state_nxt = ltip_pkg::S_DONE;
        end else if (!en_r) begin
          state_nxt = ltip_pkg::S_T_DIRECT;
        end else begin
          state_nxt = ltip_pkg::S_T_OLD;
        end
      end
      ltip_pkg::S_T_OLD: begin
        state_nxt = (play_r < stamp_q_s) ? ltip_pkg::S_DONE : ltip_pkg::S_T_NEW;
      end
      ltip_pkg::S_T_NEW: begin
        state_nxt = (play_r >= stamp_q_s) ? ltip_pkg::S_T_DIRECT : ltip_pkg::S_T_SCAN_RD;
      end
      ltip_pkg::S_T_SCAN_RD: state_nxt = ltip_pkg::S_T_SCAN_CHK;
      ltip_pkg::S_T_SCAN_CHK: begin
        if (stamp_q_s < play_r) begin
          state_nxt = ltip_pkg::S_T_SCAN_RD;
        end else if (gap_cur == '0 || gap_cur > {24'd0, gap_eff}) begin
          state_nxt = ltip_pkg::S_T_DIRECT;
        end else begin
          state_nxt = ltip_pkg::S_T_DIV;
        end
      end
      ltip_pkg::S_T_DIV:    state_nxt = div_done ? ltip_pkg::S_T_RDA : ltip_pkg::S_T_DIV;
      ltip_pkg::S_T_RDA:    state_nxt = ltip_pkg::S_T_RDB;
      ltip_pkg::S_T_RDB:    state_nxt = ltip_pkg::S_T_MUL1;
      ltip_pkg::S_T_DIRECT: state_nxt = ltip_pkg::S_T_HOLD;
      ltip_pkg::S_T_HOLD:   state_nxt = ltip_pkg::S_T_MUL1;
      ltip_pkg::S_T_MUL1:   state_nxt = ltip_pkg::S_T_RAW;
      ltip_pkg::S_T_RAW:    state_nxt = ltip_pkg::S_T_MUL2;
      ltip_pkg::S_T_MUL2:   state_nxt = fvalid_r ? ltip_pkg::S_T_UPD : ltip_pkg::S_DONE;
      ltip_pkg::S_T_UPD:    state_nxt = ltip_pkg::S_DONE;
      ltip_pkg::S_DONE:     state_nxt = ltip_pkg::S_IDLE;
      default:              state_nxt = ltip_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    fvalid_nxt = fvalid_r;
    status_nxt = status_r;
    prev_nxt   = prev_r;
    pv_nxt     = pv_r;
    nx_nxt     = nx_r;
    dir_nxt    = dir_r;
    ratio_nxt  = ratio_r;
    rd_addr    = oldest_r;
    wr_addr    = slot_of(oldest_r, count_r);
    wr_en      = 1'b0;
    hold_en    = 1'b0;
    div_go     = 1'b0;
    lane_ctl   = '0;
    out_strobe = 1'b0;
    unique case (state_r)
      ltip_pkg::S_IDLE: begin
        if (accept) begin
          status_nxt = ltip_pkg::STAT_OK;
        end
      end
      ltip_pkg::S_START: begin
        // load the current positions and drop every buffered sample
        lane_ctl.load_start = 1'b1;
        fvalid_nxt = 1'b1;
        oldest_nxt = '0;
        count_nxt  = '0;
      end
      ltip_pkg::S_P_RD: begin
        rd_addr = slot_of(oldest_r, count_r - CW'(1));
      end
      ltip_pkg::S_P_CHK: begin
        if (stamp_r == '0) begin
          status_nxt = ltip_pkg::STAT_NO_STAMP;
        end else if (stale) begin
          status_nxt = ltip_pkg::STAT_STALE;
        end else if (count_r != '0 && stamp_r <= stamp_q_r) begin
          status_nxt = ltip_pkg::STAT_BACKWARD;
        end else begin
          // a full ring overwrites its oldest slot
          wr_en = 1'b1;
          if (full) begin
            wr_addr    = oldest_r;
            oldest_nxt = slot_of(oldest_r, CW'(1));
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      ltip_pkg::S_P_TRIM_RD: begin
        rd_addr = oldest_r;
      end
      ltip_pkg::S_P_TRIM_CHK: begin
        if ({1'b0, stamp_q_r} + {24'd0, keep} < {1'b0, stamp_r}) begin
          oldest_nxt = slot_of(oldest_r, CW'(1));
          count_nxt  = count_r - CW'(1);
        end
      end
      ltip_pkg::S_T_BEGIN: begin
        rd_addr   = oldest_r;
        dir_nxt   = slot_of(oldest_r, count_r - CW'(1));
        ratio_nxt = '0;
      end
      ltip_pkg::S_T_OLD: begin
        rd_addr  = dir_r;
        prev_nxt = stamp_q_r;
        pv_nxt   = oldest_r;
        idx_nxt  = CW'(1);
      end
      ltip_pkg::S_T_NEW: begin
        rd_addr = dir_r;
      end
      ltip_pkg::S_T_SCAN_RD: begin
        rd_addr = slot_of(oldest_r, idx_r);
      end
      ltip_pkg::S_T_SCAN_CHK: begin
        if (stamp_q_s < play_r) begin
          // advance the bracket by one entry
          prev_nxt = stamp_q_r;
          pv_nxt   = slot_of(oldest_r, idx_r);
          idx_nxt  = idx_r + CW'(1);
        end else if (gap_cur == '0) begin
          dir_nxt = slot_of(oldest_r, idx_r);
        end else if (gap_cur > {24'd0, gap_eff}) begin
          dir_nxt = pv_r;
        end else begin
          nx_nxt = slot_of(oldest_r, idx_r);
          div_go = 1'b1;
        end
      end
      ltip_pkg::S_T_DIV: begin
        if (div_done) begin
          ratio_nxt = div_quot;
        end
      end
      ltip_pkg::S_T_RDA: begin
        rd_addr = pv_r;
      end
      ltip_pkg::S_T_RDB: begin
        rd_addr = nx_r;
        hold_en = 1'b1;
      end
      ltip_pkg::S_T_DIRECT: begin
        rd_addr = dir_r;
      end
      ltip_pkg::S_T_HOLD: begin
        rd_addr = dir_r;
        hold_en = 1'b1;
      end
      ltip_pkg::S_T_MUL1: begin
        lane_ctl.mul1_en = 1'b1;
      end
      ltip_pkg::S_T_RAW: begin
        lane_ctl.raw_en = 1'b1;
      end
      ltip_pkg::S_T_MUL2: begin
        // the first raw target loads the filter directly
        lane_ctl.mul2_en  = fvalid_r;
        lane_ctl.load_raw = !fvalid_r;
        fvalid_nxt        = 1'b1;
      end
      ltip_pkg::S_T_UPD: begin
        lane_ctl.upd_en = 1'b1;
      end
      ltip_pkg::S_DONE: begin
        out_strobe = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ltip_pkg::S_IDLE;
      oldest_r <= '0;
      count_r  <= '0;
      idx_r    <= '0;
      fvalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      fvalid_r <= fvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req;
      stamp_r <= stamp_in;
      play_r  <= $signed({2'b00, in_req.now_time}) - $signed({26'd0, delay_r});
    end
    status_r <= status_nxt;
    prev_r   <= prev_nxt;
    pv_r     <= pv_nxt;
    nx_r     <= nx_nxt;
    dir_r    <= dir_nxt;
    ratio_r  <= ratio_nxt;
    if (hold_en) begin
      hold_r <= pos_q_r;
    end
  end

  // sample memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= stamp_r;
      pos_mem[wr_addr]   <= req_row;
    end
    stamp_q_r <= stamp_mem[rd_addr];
    pos_q_r   <= pos_mem[rd_addr];
  end

  ltip_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (play_diff[23:0]),
    .den   (gap_cur[23:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  for (genvar g = 0; g < JC; g++) begin : g_lane
    ltip_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (lane_ctl),
      .pos_a     (hold_r[g]),
      .pos_b     (pos_q_r[g]),
      .ratio     (ratio_r),
      .alpha     (alpha_eff),
      .start_pos (req_row[g]),
      .filt      (filt[g])
    );
  end

  // merge the lanes into the response
  assign out_rsp.status       = status_r;
  assign out_rsp.target_valid = fvalid_r;
  assign out_rsp.out_0        = filt[0];
  assign out_rsp.out_1        = filt[1];
  assign out_rsp.out_2        = filt[2];
  assign out_rsp.out_3        = filt[3];
  assign out_rsp.out_4        = filt[4];
  assign out_rsp.out_5        = filt[5];
  assign out_rsp.out_6        = filt[6];

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BUFFER_DEPTH))
    else $error("entry count beyond buffer depth");

  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fvalid_r |=> fvalid_r)
    else $error("filtered target lost its valid flag");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy && (state_nxt == ltip_pkg::S_IDLE))
    else $error("result strobe outside the final cycle");
`endif

endmodule
